[rtl/core/rssi_sorted_scan_list_core_defines.svh]
// Assertion macros for the RSSI sorted scan list core.
// Used by the port checker; needs a clock named i_clk and reset i_rst_n in scope.
`ifndef RSSI_SORTED_SCAN_LIST_CORE_DEFINES_SVH
`define RSSI_SORTED_SCAN_LIST_CORE_DEFINES_SVH

// Checked only outside reset.
`define RSSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define RSSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/rssl_pkg.sv]
// Shared types and request codes for the RSSI sorted scan list core.
// No dependencies; used by rssl_cell and rssi_sorted_scan_list_core.
package rssl_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // One stored peer, 61 bits.
    typedef struct packed {
        logic [47:0]       addr;
        logic signed [7:0] rssi;
        logic [1:0]        atype;
        logic [2:0]        etype;
    } t_entry;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;   // insert the new entry, shifting weaker ones right
        logic rot;   // rotate the whole row one place towards cell 0
    } t_cell_ctl;

    // Result transaction, packed lowest field in bit 0.
    typedef struct packed {
        logic [2:0]        read_event_type;
        logic [1:0]        read_addr_type;
        logic signed [7:0] read_rssi;
        logic [47:0]       read_addr;
        logic              read_valid;
        logic [4:0]        entry_count;
        logic [3:0]        insert_pos;
        logic              accepted;
    } t_result;

endpackage

[rtl/core/rssl_cell.sv]
// One position of the sorted list: holds an entry and trades it with its neighbours.
// Depends on rssl_pkg.
module rssl_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                i_clk,
    input  rssl_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_count,
    input  rssl_pkg::t_entry    i_new,
    input  rssl_pkg::t_entry    i_left,
    input  rssl_pkg::t_entry    i_right,
    input  logic                i_take_prev,
    output logic                o_take,
    output logic                o_first,
    output rssl_pkg::t_entry    o_entry
);

    rssl_pkg::t_entry r_entry;
    rssl_pkg::t_entry n_entry;
    logic             w_greater;
    logic             w_at_end;

    // Occupied and strictly weaker than the new entry: it must move right.
    assign w_greater = (CW'(IDX) < i_count) && (i_new.rssi > r_entry.rssi);
    assign w_at_end  = (i_count == CW'(IDX));
    assign o_take    = w_greater || w_at_end;
    assign o_first   = o_take && !i_take_prev;
    assign o_entry   = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins && o_take) begin
            n_entry = i_take_prev ? i_left : i_new;
        end else if (i_ctl.rot) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[rtl/core/rssi_sorted_scan_list_core.sv]
// Top level of the RSSI sorted scan list: control, output register and row of cells.
// Depends on rssl_pkg and rssl_cell.
//
// Usage
//   Requests arrive on s_axis: tuser carries the request kind (insert, clear,
//   read), tdata the peer fields and the read index. Every request gives exactly
//   one result transaction on m_axis, in request order.
//   Insert and clear: the list updates in the accepting cycle and the result is
//   shown in the cycle after acceptance. Insert places the entry before the first
//   stored entry with strictly lower RSSI (ties go after older entries); a full
//   list drops it with accepted = 0.
//   Read: the row of cells is rotated a full turn, one place a cycle, and the
//   entry passing cell 0 at the requested step is captured, so the result shows
//   once the turn is complete and the list ends where it began.
//   Throughput: one request per cycle for insert and clear while the receiver
//   takes each result; a read holds off new requests until the rotation of the
//   cell row ends and the core is back in idle.
//   Reset (synchronous, active low) empties the list and drops any pending
//   result; entry contents are not cleared, only the count.
//   A stalled receiver holds the result in the output register; a new request
//   is taken in the cycle that result is taken, not before.
module rssi_sorted_scan_list_core #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: peer_addr[47:0], new_rssi[55:48], addr_type[57:56],
    //        event_type[60:58], read_index[64:61], zero fill [71:65]
    input  logic [71:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: accepted[0], insert_pos[4:1], entry_count[9:5], read_valid[10],
    //        read_addr[58:11], read_rssi[66:59], read_addr_type[68:67],
    //        read_event_type[71:69]
    output logic [71:0] m_axis_tdata
);

    localparam int CW = $clog2(LIST_DEPTH + 1);    // count width
    localparam int SW = $clog2(LIST_DEPTH);        // position / step width
    localparam int EW = (CW > 4) ? CW : 4;         // common width for index compares

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [SW-1:0]       r_step, n_step;
    logic                r_ovalid, n_ovalid;
    rssl_pkg::t_result   r_out, n_out;
    logic [3:0]          r_ridx, n_ridx;
    logic                r_rvalid, n_rvalid;

    rssl_pkg::t_entry    w_new;
    logic [1:0]          w_req;
    logic [3:0]          w_ridx;
    logic                w_acc;
    logic                w_full;
    rssl_pkg::t_cell_ctl w_ctl;
    rssl_pkg::t_entry    w_entry [LIST_DEPTH];
    logic [LIST_DEPTH:0] w_take;        // w_take[k] feeds cell k as its left flag
    logic [LIST_DEPTH-1:0] w_first;
    logic [SW-1:0]       w_pos;

    // Field unpack
    assign w_req       = s_axis_tuser;
    assign w_new.addr  = s_axis_tdata[47:0];
    assign w_new.rssi  = s_axis_tdata[55:48];
    assign w_new.atype = s_axis_tdata[57:56];
    assign w_new.etype = s_axis_tdata[60:58];
    assign w_ridx      = s_axis_tdata[64:61];

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CW'(LIST_DEPTH));

    assign w_ctl.ins = w_acc && (w_req == rssl_pkg::REQ_INSERT) && !w_full;
    assign w_ctl.rot = (r_state == ST_READ);

    // Row of cells; rotation moves entry k+1 into cell k, cell 0 wraps to the end.
    assign w_take[0] = 1'b0;
    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        rssl_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_new       (w_new),
            .i_left      ((k == 0) ? '0 : w_entry[(k == 0) ? 0 : k - 1]),
            .i_right     (w_entry[(k + 1) % LIST_DEPTH]),
            .i_take_prev (w_take[k]),
            .o_take      (w_take[k+1]),
            .o_first     (w_first[k]),
            .o_entry     (w_entry[k])
        );
    end

    // Insert position: index of the one cell that takes the new entry.
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (w_first[k]) begin
                w_pos = w_pos | SW'(k);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_step   = r_step;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        n_ridx   = r_ridx;
        n_rvalid = r_rvalid;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_out    = '0;
                    n_rvalid = 1'b0;
                    unique case (w_req)
                        rssl_pkg::REQ_INSERT: begin
                            if (!w_full) begin
                                n_count          = r_count + 1'b1;
                                n_out.accepted   = 1'b1;
                                n_out.insert_pos = 4'(w_pos);
                            end
                        end
                        rssl_pkg::REQ_CLEAR: begin
                            n_count = '0;
                        end
                        rssl_pkg::REQ_READ: begin
                            n_state  = ST_READ;
                            n_step   = '0;
                            n_ridx   = w_ridx;
                            n_rvalid = EW'(w_ridx) < EW'(r_count);
                        end
                        default: begin
                        end
                    endcase
                    n_out.entry_count = 5'(n_count);
                    if (w_req != rssl_pkg::REQ_READ) begin
                        n_ovalid = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_step = SW'(r_step + 1'b1);
                // After r_step rotations cell 0 holds list entry r_step.
                if (r_rvalid && (EW'(r_step) == EW'(r_ridx))) begin
                    n_out.read_valid      = 1'b1;
                    n_out.read_addr       = w_entry[0].addr;
                    n_out.read_rssi       = w_entry[0].rssi;
                    n_out.read_addr_type  = w_entry[0].atype;
                    n_out.read_event_type = w_entry[0].etype;
                end
                if (r_step == SW'(LIST_DEPTH - 1)) begin
                    n_state  = ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_ridx   <= n_ridx;
        r_rvalid <= n_rvalid;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

endmodule

[rtl/core/rssl_checker.sv]
// Port-level checks for rssi_sorted_scan_list_core, attached by bind.
// Depends on rssi_sorted_scan_list_core_defines.svh.
`include "rssi_sorted_scan_list_core_defines.svh"

module rssl_checker #(
    parameter int LIST_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    localparam int MAX_COUNT = (LIST_DEPTH > 31) ? 31 : LIST_DEPTH;

    // Reset drops any pending result transaction.
    `RSSL_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // A stalled result holds.
    `RSSL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // No new request taken while the result register is blocked.
    `RSSL_ASSERT(a_no_accept_on_stall, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "request taken during output stall")

    // Count stays within the list, and an accepted insert result never carries read data.
    `RSSL_ASSERT(a_count_range, m_axis_tvalid |-> (m_axis_tdata[9:5] <= MAX_COUNT) && !(m_axis_tdata[0] && m_axis_tdata[10]), "bad count or mixed result")

endmodule

bind rssi_sorted_scan_list_core rssl_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_rssl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/rssi_sorted_scan_list_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rssi_sorted_scan_list_core: directed table, then random traffic.
// Depends on rssl_pkg and the core RTL; predicts every result with its own list model.
module rssi_sorted_scan_list_core_tb;

    localparam int LIST_DEPTH      = 16;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int PHASE_ITEMS     = 333;
    // Request code with no operation behind it; the core must answer with the count only.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Request fields as packed onto s_axis_tdata, lowest field in bit 0.
    typedef struct packed {
        logic [6:0]        pad;
        logic [3:0]        ridx;
        logic [2:0]        etype;
        logic [1:0]        atype;
        logic signed [7:0] rssi;
        logic [47:0]       addr;
    } t_req_fields;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        logic [1:0]        kind;
        t_req_fields       f;
        bit                typed;
        rssl_pkg::t_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // peer_addr, new_rssi, addr_type, event_type, read_index
    logic [1:0]  s_axis_tuser = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // accepted, insert_pos, entry_count, read_valid,
                                      // read_addr, read_rssi, read_addr_type, read_event_type

    // Own copy of the peer list, updated as requests are accepted
    rssl_pkg::t_entry  peer_list [LIST_DEPTH];
    int                n_peers = 0;

    rssl_pkg::t_result pending_results [$];    // expected results, oldest first
    rssl_pkg::t_result typed_results [int];    // hand-written expectations keyed by request number
    int      n_accepted = 0;         // requests seen accepted by the core
    int      n_sent = 0;             // requests issued by the sender
    int      gen_count = 0;          // list fill as seen by the stimulus generator
    int      n_fail = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    rssi_sorted_scan_list_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: ready drops at random, at the rate the current phase sets.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Works out the result of one request and moves the list on.
    // Placement: before the first entry with strictly lower RSSI, so ties go after older ones.
    function automatic rssl_pkg::t_result predict_scan_list(logic [1:0] kind, t_req_fields f);
        rssl_pkg::t_result r;
        int      pos;
        int      k;
        r = '0;
        case (kind)
            rssl_pkg::REQ_INSERT: begin
                if (n_peers < LIST_DEPTH) begin
                    pos = n_peers;
                    for (k = 0; k < n_peers; k++) begin
                        if (pos == n_peers && $signed(f.rssi) > $signed(peer_list[k].rssi))
                            pos = k;
                    end
                    for (k = n_peers; k > pos; k--)
                        peer_list[k] = peer_list[k - 1];
                    peer_list[pos].addr  = f.addr;
                    peer_list[pos].rssi  = f.rssi;
                    peer_list[pos].atype = f.atype;
                    peer_list[pos].etype = f.etype;
                    n_peers++;
                    r.accepted   = 1'b1;
                    r.insert_pos = pos[3:0];
                end
                // full list: dropped, nothing but the count is reported
            end
            rssl_pkg::REQ_CLEAR: n_peers = 0;
            rssl_pkg::REQ_READ: begin
                // out of range reads leave every read field at zero
                if (int'(f.ridx) < n_peers) begin
                    r.read_valid      = 1'b1;
                    r.read_addr       = peer_list[f.ridx].addr;
                    r.read_rssi       = peer_list[f.ridx].rssi;
                    r.read_addr_type  = peer_list[f.ridx].atype;
                    r.read_event_type = peer_list[f.ridx].etype;
                end
            end
            default: ;   // unused code: no operation
        endcase
        r.entry_count = n_peers[4:0];
        return r;
    endfunction

    task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // Scoreboard: both handshakes are sampled at the edge, before the core's registers move.
    // A result always shows in a later cycle than its request, so the order here is free.
    always @(posedge i_clk) begin
        rssl_pkg::t_result got;
        rssl_pkg::t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_axis_tdata);
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("accepted",        64'(want.accepted),    64'(got.accepted));
                    cmp_field("insert_pos",      64'(want.insert_pos),  64'(got.insert_pos));
                    cmp_field("entry_count",     64'(want.entry_count), 64'(got.entry_count));
                    cmp_field("read_valid",      64'(want.read_valid),  64'(got.read_valid));
                    cmp_field("read_addr",       64'(want.read_addr),   64'(got.read_addr));
                    cmp_field("read_rssi",       64'(want.read_rssi),   64'(got.read_rssi));
                    cmp_field("read_addr_type",  64'(want.read_addr_type),
                              64'(got.read_addr_type));
                    cmp_field("read_event_type", 64'(want.read_event_type),
                              64'(got.read_event_type));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_scan_list(s_axis_tuser, t_req_fields'(s_axis_tdata));
                // a typed-in expectation replaces the prediction; the list still moves on
                if (typed_results.exists(n_accepted))
                    want = typed_results[n_accepted];
                pending_results.push_back(want);
                n_accepted++;
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_stim_row mk_row(logic [1:0] kind, logic [47:0] addr,
                                         logic signed [7:0] rssi, logic [1:0] atype,
                                         logic [2:0] etype, logic [3:0] ridx,
                                         bit typed, rssl_pkg::t_result want);
        t_stim_row row;
        row.kind    = kind;
        row.f.pad   = '0;
        row.f.ridx  = ridx;
        row.f.etype = etype;
        row.f.atype = atype;
        row.f.rssi  = rssi;
        row.f.addr  = addr;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    function automatic rssl_pkg::t_result want_res(bit acc, logic [3:0] pos, logic [4:0] cnt,
                                                   bit rv, logic [47:0] addr,
                                                   logic signed [7:0] rssi,
                                                   logic [1:0] atype, logic [2:0] etype);
        rssl_pkg::t_result r;
        r.accepted        = acc;
        r.insert_pos      = pos;
        r.entry_count     = cnt;
        r.read_valid      = rv;
        r.read_addr       = addr;
        r.read_rssi       = rssi;
        r.read_addr_type  = atype;
        r.read_event_type = etype;
        return r;
    endfunction

    // One request: hold it until the core takes it, then idle for a random gap.
    // tvalid is only lowered when a gap follows, so it never drops and rises in one step.
    task automatic send_req(logic [1:0] kind, t_req_fields f);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
        if (kind == rssl_pkg::REQ_INSERT && gen_count < LIST_DEPTH)
            gen_count++;
        else if (kind == rssl_pkg::REQ_CLEAR)
            gen_count = 0;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender stands back until every request is booked and every expected result taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (n_accepted < n_sent || pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_stim_row   dir_rows [$];
        t_stim_row   row;
        t_req_fields f;
        logic [1:0]  kind;
        int          pick;
        int          ph;
        int          i;

        // Directed table: empty list, unused code, a fill to the brim with ties and
        // extremes, an insert on a full list, reads in and out of range, clear.
        dir_rows.push_back(mk_row(rssl_pkg::REQ_READ, '0, 0, 0, 0, 4'd0, 1,
                                  want_res(0, 0, 0, 0, '0, 0, 0, 0)));
        dir_rows.push_back(mk_row(REQ_UNUSED, 48'hFFFF_FFFF_FFFF, -1, 3, 7, 4'hF, 1,
                                  want_res(0, 0, 0, 0, '0, 0, 0, 0)));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_CLEAR, '0, 0, 0, 0, 4'd0, 1,
                                  want_res(0, 0, 0, 0, '0, 0, 0, 0)));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, '0, 0, 0, 0, 4'd0, 1,
                                  want_res(1, 0, 1, 0, '0, 0, 0, 0)));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'hFFFF_FFFF_FFFF, 127, 3, 7, 4'hF, 1,
                                  want_res(1, 0, 2, 0, '0, 0, 0, 0)));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h0123_4567_89AB, -128, 1, 2, 4'd5, 1,
                                  want_res(1, 2, 3, 0, '0, 0, 0, 0)));
        // ties with older entries: must land after them
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'hA5A5_5A5A_0F0F, 0, 2, 5, 4'd10, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h8000_0000_0001, 127, 0, 4, 4'd1, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h0000_0000_0001, -1, 1, 1, 4'd2, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h1111_2222_3333, 1, 2, 3, 4'd3, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h4444_5555_6666, -127, 3, 6, 4'd4, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h7777_8888_9999, 64, 0, 0, 4'd6, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'hAAAA_BBBB_CCCC, -64, 1, 7, 4'd7, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'hDDDD_EEEE_FFFF, 126, 2, 2, 4'd8, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h0F0F_F0F0_0F0F, -128, 3, 5, 4'd9, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'hF0F0_0F0F_F0F0, 0, 0, 1, 4'd11, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h1357_9BDF_2468, 50, 1, 4, 4'd12, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h2468_ACE0_1357, -50, 2, 6, 4'd13, 0,
                                  '0));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'h5A5A_A5A5_5A5A, 100, 3, 3, 4'd14, 0,
                                  '0));
        // list now full: dropped, count unchanged
        dir_rows.push_back(mk_row(rssl_pkg::REQ_INSERT, 48'hCAFE_0000_BEEF, 127, 3, 7, 4'd0, 1,
                                  want_res(0, 0, 16, 0, '0, 0, 0, 0)));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_READ, '0, 0, 0, 0, 4'd0, 1,
                                  want_res(0, 0, 16, 1, 48'hFFFF_FFFF_FFFF, 127, 3, 7)));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_READ, 48'hFFFF_FFFF_FFFF, -1, 3, 7, 4'd15, 0,
                                  '0));
        dir_rows.push_back(mk_row(REQ_UNUSED, '0, 0, 0, 0, 4'd0, 1,
                                  want_res(0, 0, 16, 0, '0, 0, 0, 0)));
        dir_rows.push_back(mk_row(rssl_pkg::REQ_CLEAR, 48'hFFFF_FFFF_FFFF, 127, 3, 7, 4'hF, 1,
                                  want_res(0, 0, 0, 0, '0, 0, 0, 0)));
        // read beyond the count after clear: all read fields zero
        dir_rows.push_back(mk_row(rssl_pkg::REQ_READ, '0, 0, 0, 0, 4'd15, 1,
                                  want_res(0, 0, 0, 0, '0, 0, 0, 0)));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.typed)
                typed_results[n_sent] = row.want;
            send_req(row.kind, row.f);
        end
        drain_results();

        // Random phases, each with its own idle/stall profile; the list is driven
        // through fill, full and clear cycles with reads mostly inside the count.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                f.pad   = '0;
                f.addr  = {16'($urandom()), $urandom()};
                f.atype = 2'($urandom_range(3));
                f.etype = 3'($urandom_range(7));
                f.ridx  = 4'($urandom_range(15));
                // tie-prone values half the time so equal keys meet often
                if ($urandom_range(1)) begin
                    case ($urandom_range(4))
                        0: f.rssi = -128;
                        1: f.rssi = 127;
                        2: f.rssi = 0;
                        default: f.rssi = -70;
                    endcase
                end else begin
                    f.rssi = 8'($urandom_range(255));
                end
                pick = $urandom_range(99);
                if (pick < 62) begin
                    kind = rssl_pkg::REQ_INSERT;
                end else if (pick < 94) begin
                    kind = rssl_pkg::REQ_READ;
                    if (gen_count > 0 && $urandom_range(3) != 0)
                        f.ridx = 4'($urandom_range(gen_count - 1));
                end else if (pick < 97) begin
                    kind = rssl_pkg::REQ_CLEAR;
                end else begin
                    kind = REQ_UNUSED;
                end
                send_req(kind, f);
            end
            drain_results();
        end

        // Tail: let any stray result show before the verdict; a read takes a full turn.
        repeat (2 * LIST_DEPTH + 4) @(posedge i_clk);
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
